FILE: src/bpa_pkg.sv
// bpa_pkg: shared constants, codes and types of the buddy page allocator.
// No dependencies; used by the sequencer, the store and the top level.
package bpa_pkg;

  localparam int MAX_PAGES_DEF  = 1024;
  localparam int MAX_ORDERS_DEF = 11;
  localparam int PAGE_SHIFT_DEF = 12;

  // order values (0 to 31) and page tags share this width
  localparam int ORD_W = 5;
  localparam int TAG_W = 5;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_BLOCK  = 3'd1;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;
  localparam logic [2:0] ST_BAD_RANGE = 3'd5;

  localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] CFG_HEAP_PAGES = 2'd1;
  localparam logic [1:0] CFG_ORDERS     = 2'd2;

  typedef struct packed {
    logic             mark_we;
    logic             mark_wd;
    logic             tag_we;
    logic [TAG_W-1:0] tag_wd;
  } bpa_mem_ctl_t;

  // smallest order whose block holds pc pages (pc >= 1): bit length of pc-1
  function automatic logic [3:0] ceil_order(input logic [10:0] pc);
    logic [10:0] v;
    logic [3:0]  r;
    v = pc - 11'd1;
    r = 4'd0;
    for (int b = 0; b < 11; b++) begin
      if (v[b]) r = 4'(b + 1);
    end
    return r;
  endfunction

endpackage

FILE: src/bpa_ifs.sv
// bpa_ifs: request and result channel interfaces of the buddy page allocator.
// Plain valid/ready channels; no package dependency.
interface bpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] page_count;
  logic [47:0] release_address;
  logic [9:0]  range_first;
  logic [10:0] range_past_last;

  modport source (output valid, command, page_count, release_address, range_first,
                  range_past_last, input ready);
  modport sink (input valid, command, page_count, release_address, range_first,
                range_past_last, output ready);
endinterface

interface bpa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] block_address;
  logic [48:0] block_end_address;
  logic [3:0]  block_order;

  modport source (output valid, status, block_address, block_end_address, block_order,
                  input ready);
  modport sink (input valid, status, block_address, block_end_address, block_order,
                output ready);
endinterface

FILE: src/bpa_store.sv
// bpa_store: order mark bitmap and page order tag memories.
// Depends on bpa_pkg for the control struct and tag width.
module bpa_store #(
  parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF
) (
  input  logic                       clk,
  input  bpa_pkg::bpa_mem_ctl_t      mem_ctl,
  input  logic [$clog2(MAX_ORDERS << $clog2(MAX_PAGES))-1:0] mark_waddr,
  input  logic [$clog2(MAX_ORDERS << $clog2(MAX_PAGES))-1:0] mark_raddr,
  input  logic [$clog2(MAX_PAGES)-1:0] tag_waddr,
  input  logic [$clog2(MAX_PAGES)-1:0] tag_raddr,
  output logic                       mark_rdata_r,
  output logic [bpa_pkg::TAG_W-1:0]  tag_rdata_r
);
  localparam int PW = $clog2(MAX_PAGES);
  localparam int MD = MAX_ORDERS << PW;

  logic                      marks [MD];
  logic [bpa_pkg::TAG_W-1:0] tags  [MAX_PAGES];

  always_ff @(posedge clk) begin
    if (mem_ctl.mark_we) begin
      marks[mark_waddr] <= mem_ctl.mark_wd;
    end
    mark_rdata_r <= marks[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.tag_we) begin
      tags[tag_waddr] <= mem_ctl.tag_wd;
    end
    tag_rdata_r <= tags[tag_raddr];
  end

endmodule

FILE: src/bpa_ctrl.sv
// bpa_ctrl: command sequencer of the buddy page allocator; scans, walks and writes
// the mark and tag memories, one request at a time. Depends on bpa_pkg and bpa_ifs.
module bpa_ctrl #(
  parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF,
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bpa_in_if.sink                in_req,
  bpa_out_if.source             out_rsp,
  input  logic [47:0]           heap_base,
  input  logic [10:0]           heap_pages,
  input  logic [3:0]            orders_in_use,
  output bpa_pkg::bpa_mem_ctl_t mem_ctl,
  output logic [$clog2(MAX_ORDERS << $clog2(MAX_PAGES))-1:0] mark_waddr,
  output logic [$clog2(MAX_ORDERS << $clog2(MAX_PAGES))-1:0] mark_raddr,
  output logic [$clog2(MAX_PAGES)-1:0] tag_waddr,
  output logic [$clog2(MAX_PAGES)-1:0] tag_raddr,
  input  logic                  mark_rdata_r,
  input  logic [bpa_pkg::TAG_W-1:0] tag_rdata_r
);
  localparam int PW  = $clog2(MAX_PAGES);
  localparam int MD  = MAX_ORDERS << PW;
  localparam int AW  = $clog2(MD);
  localparam int KA  = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int NW  = ((CW > 11) ? CW : 11) + 1;
  localparam int KW  = bpa_pkg::ORD_W;
  localparam int TW  = bpa_pkg::TAG_W;

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_DEC     = 14'b00000000000100,
    S_REL_CHK = 14'b00000000001000,
    S_TAG_RD  = 14'b00000000010000,
    S_TAG_CK  = 14'b00000000100000,
    S_SCAN_RD = 14'b00000001000000,
    S_SCAN_CK = 14'b00000010000000,
    S_RNG_SET = 14'b00000100000000,
    S_RNG_RUN = 14'b00001000000000,
    S_ANC     = 14'b00010000000000,
    S_UP_WR   = 14'b00100000000000,
    S_UP_CK   = 14'b01000000000000,
    S_ADDR    = 14'b10000000000000
  } state_t;

  // result waiting for the output register is flagged by done_r
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic [10:0]     pc_r, pc_nxt;
  logic [47:0]     addr_r, addr_nxt;
  logic [NW-1:0]   first_r, first_nxt, past_r, past_nxt, np_r, np_nxt;
  logic [KW-1:0]   no_r, no_nxt, ord_r, ord_nxt, k_r, k_nxt, kcnt_r, kcnt_nxt;
  logic [NW-1:0]   idx_r, idx_nxt, walk_r, walk_nxt, pos_r, pos_nxt, lim_r, lim_nxt;
  logic            val_r, val_nxt, rsv_r, rsv_nxt, mwe_r, mwe_nxt, bud_r, bud_nxt;
  logic [47:0]     off_r, off_nxt;
  logic [48:0]     start_r, start_nxt;
  logic            addr_ph_r, addr_ph_nxt;
  logic [2:0]      st_r, st_nxt;
  logic            blk_r, blk_nxt, done_r, done_nxt;
  logic [48:0]     end_r, end_nxt;
  logic            ov_r, ov_nxt;
  logic [2:0]      o_st_r, o_st_nxt;
  logic [47:0]     o_addr_r, o_addr_nxt;
  logic [48:0]     o_end_r, o_end_nxt;
  logic [3:0]      o_ord_r, o_ord_nxt;

  logic [KW-1:0]   ordc, sh;
  logic [NW-1:0]   lo_sub, hi_sub, lo_rsv, hi_rsv, np_cfg;
  logic [KW-1:0]   no_cfg;
  logic [47:0]     page;

  function automatic logic [AW-1:0] maddr(input logic [KW-1:0] k, input logic [NW-1:0] i);
    return AW'({k[KA-1:0], i[PW-1:0]});
  endfunction

  assign ordc   = KW'(bpa_pkg::ceil_order(pc_r));
  assign sh     = ord_r - k_r;
  assign lo_sub = idx_r << sh;
  assign hi_sub = ((lo_sub + (NW'(1) << sh)) > NW'(MAX_PAGES)) ? NW'(MAX_PAGES)
                                                               : lo_sub + (NW'(1) << sh);
  assign lo_rsv = first_r >> k_r;
  assign hi_rsv = ((past_r - NW'(1)) >> k_r) + NW'(1);
  assign np_cfg = (NW'(heap_pages) > NW'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(heap_pages);
  assign no_cfg = (KW'(orders_in_use) > KW'(MAX_ORDERS)) ? KW'(MAX_ORDERS)
                                                         : KW'(orders_in_use);
  assign page   = off_r >> PAGE_SHIFT;

  assign in_req.ready          = (state_r == S_IDLE) && !done_r;
  assign out_rsp.valid         = ov_r;
  assign out_rsp.status        = o_st_r;
  assign out_rsp.block_address = o_addr_r;
  assign out_rsp.block_end_address = o_end_r;
  assign out_rsp.block_order   = o_ord_r;

  assign tag_raddr = idx_r[PW-1:0];

  always_comb begin
    state_nxt = state_r;   clr_nxt = clr_r;     cmd_nxt = cmd_r;     pc_nxt = pc_r;
    addr_nxt = addr_r;     first_nxt = first_r; past_nxt = past_r;   np_nxt = np_r;
    no_nxt = no_r;         ord_nxt = ord_r;     k_nxt = k_r;         kcnt_nxt = kcnt_r;
    idx_nxt = idx_r;       walk_nxt = walk_r;   pos_nxt = pos_r;     lim_nxt = lim_r;
    val_nxt = val_r;       rsv_nxt = rsv_r;     mwe_nxt = mwe_r;     bud_nxt = bud_r;
    off_nxt = off_r;       start_nxt = start_r; addr_ph_nxt = addr_ph_r;
    st_nxt = st_r;         blk_nxt = blk_r;     done_nxt = done_r;   end_nxt = end_r;
    o_st_nxt = o_st_r;     o_addr_nxt = o_addr_r; o_end_nxt = o_end_r; o_ord_nxt = o_ord_r;
    ov_nxt = ov_r && !out_rsp.ready;

    mem_ctl    = '0;
    mark_waddr = maddr(k_r, pos_r);
    mark_raddr = maddr(ord_r, pos_r);
    tag_waddr  = pos_r[PW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        mem_ctl.mark_we = 1'b1;
        mark_waddr      = clr_r;
        mem_ctl.tag_we  = ({1'b0, clr_r} < (AW+1)'(MAX_PAGES));
        tag_waddr       = clr_r[PW-1:0];
        clr_nxt         = clr_r + AW'(1);
        if (clr_r == AW'(MD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req.valid && !done_r) begin
          cmd_nxt   = in_req.command;
          pc_nxt    = in_req.page_count;
          addr_nxt  = in_req.release_address;
          first_nxt = NW'(in_req.range_first);
          past_nxt  = NW'(in_req.range_past_last);
          np_nxt    = np_cfg;
          no_nxt    = no_cfg;
          st_nxt    = bpa_pkg::ST_OK;
          blk_nxt   = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        done_nxt  = 1'b1;
        case (cmd_r)
          bpa_pkg::CMD_ALLOC: begin
            if (pc_r == 11'd0) begin
              st_nxt = bpa_pkg::ST_ZERO_SIZE;
            end else if (ordc >= no_r) begin
              st_nxt = bpa_pkg::ST_NO_BLOCK;
            end else begin
              ord_nxt   = ordc;
              pos_nxt   = '0;
              lim_nxt   = np_r >> ordc;
              done_nxt  = 1'b0;
              state_nxt = S_SCAN_RD;
            end
          end
          bpa_pkg::CMD_RELEASE: begin
            if (addr_r < heap_base) begin
              st_nxt = bpa_pkg::ST_OUTSIDE;
            end else begin
              off_nxt   = addr_r - heap_base;
              done_nxt  = 1'b0;
              state_nxt = S_REL_CHK;
            end
          end
          bpa_pkg::CMD_RESERVE: begin
            if (first_r > past_r || past_r > np_r) begin
              st_nxt = bpa_pkg::ST_BAD_RANGE;
            end else if (first_r != past_r) begin
              rsv_nxt   = 1'b1;
              mwe_nxt   = (no_r != '0);
              k_nxt     = '0;
              kcnt_nxt  = (no_r == '0) ? KW'(1) : no_r;
              done_nxt  = 1'b0;
              state_nxt = S_RNG_SET;
            end
          end
          default: st_nxt = bpa_pkg::ST_BAD_RANGE;
        endcase
      end
      S_REL_CHK: begin
        if (page >= 48'(np_r)) begin
          st_nxt    = bpa_pkg::ST_OUTSIDE;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = NW'(page);
          state_nxt = S_TAG_RD;
        end
      end
      S_TAG_RD: state_nxt = S_TAG_CK;
      S_TAG_CK: begin
        if (tag_rdata_r == '0 || tag_rdata_r > TW'(MAX_ORDERS)) begin
          st_nxt    = bpa_pkg::ST_NOT_ALLOC;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ord_nxt   = KW'(tag_rdata_r - TW'(1));
          idx_nxt   = idx_r >> (tag_rdata_r - TW'(1));
          val_nxt   = 1'b0;
          rsv_nxt   = 1'b0;
          mwe_nxt   = 1'b1;
          k_nxt     = '0;
          kcnt_nxt  = KW'(tag_rdata_r);
          state_nxt = S_RNG_SET;
        end
      end
      S_SCAN_RD: begin
        if (pos_r >= lim_r) begin
          st_nxt    = bpa_pkg::ST_NO_BLOCK;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (!mark_rdata_r) begin
          idx_nxt   = pos_r;
          val_nxt   = 1'b1;
          rsv_nxt   = 1'b0;
          mwe_nxt   = 1'b1;
          k_nxt     = '0;
          kcnt_nxt  = ord_r + KW'(1);
          state_nxt = S_RNG_SET;
        end else begin
          pos_nxt   = pos_r + NW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_RNG_SET: begin
        pos_nxt   = rsv_r ? lo_rsv : lo_sub;
        lim_nxt   = rsv_r ? hi_rsv : hi_sub;
        state_nxt = S_RNG_RUN;
      end
      S_RNG_RUN: begin
        if (pos_r < lim_r) begin
          mem_ctl.mark_we = mwe_r;
          mem_ctl.mark_wd = rsv_r | val_r;
          mem_ctl.tag_we  = (k_r == '0);
          mem_ctl.tag_wd  = rsv_r ? TW'(1) : (val_r ? TW'(ord_r + KW'(1)) : '0);
          pos_nxt         = pos_r + NW'(1);
        end else if (k_r + KW'(1) >= kcnt_r) begin
          // last level swept: finish a reserve, else move on to the ancestor walk
          k_nxt    = ord_r;
          walk_nxt = idx_r;
          if (rsv_r) begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = val_r ? S_ANC : S_UP_WR;
          end
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_RNG_SET;
        end
      end
      S_ANC: begin
        if (k_r < no_r) begin
          mem_ctl.mark_we = 1'b1;
          mem_ctl.mark_wd = 1'b1;
          mark_waddr      = maddr(k_r, walk_r);
          walk_nxt        = walk_r >> 1;
          k_nxt           = k_r + KW'(1);
        end else begin
          addr_ph_nxt = 1'b0;
          state_nxt   = S_ADDR;
        end
      end
      S_UP_WR: begin
        if (k_r < no_r) begin
          mem_ctl.mark_we = 1'b1;
          mem_ctl.mark_wd = 1'b0;
          mark_waddr      = maddr(k_r, walk_r);
          mark_raddr      = maddr(k_r, walk_r ^ NW'(1));
          bud_nxt         = ((walk_r ^ NW'(1)) < NW'(MAX_PAGES));
          state_nxt       = S_UP_CK;
        end else begin
          addr_ph_nxt = 1'b0;
          state_nxt   = S_ADDR;
        end
      end
      S_UP_CK: begin
        if (bud_r && mark_rdata_r) begin
          addr_ph_nxt = 1'b0;
          state_nxt   = S_ADDR;
        end else begin
          walk_nxt  = walk_r >> 1;
          k_nxt     = k_r + KW'(1);
          state_nxt = S_UP_WR;
        end
      end
      S_ADDR: begin
        if (!addr_ph_r) begin
          start_nxt   = 49'(heap_base) + (49'(idx_r << ord_r) << PAGE_SHIFT);
          addr_ph_nxt = 1'b1;
        end else begin
          end_nxt   = start_r + (49'(1) << (ord_r + KW'(PAGE_SHIFT)));
          blk_nxt   = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    // hand the finished result to the output register once it is free
    if (done_r && (!ov_r || out_rsp.ready)) begin
      done_nxt   = 1'b0;
      ov_nxt     = 1'b1;
      o_st_nxt   = st_r;
      o_addr_nxt = blk_r ? start_r[47:0] : '0;
      o_end_nxt  = blk_r ? end_r : '0;
      o_ord_nxt  = blk_r ? ord_r[3:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;     pc_r <= pc_nxt;       addr_r <= addr_nxt;
    first_r <= first_nxt; past_r <= past_nxt;   np_r <= np_nxt;     no_r <= no_nxt;
    ord_r <= ord_nxt;     k_r <= k_nxt;         kcnt_r <= kcnt_nxt; idx_r <= idx_nxt;
    walk_r <= walk_nxt;   pos_r <= pos_nxt;     lim_r <= lim_nxt;   val_r <= val_nxt;
    rsv_r <= rsv_nxt;     mwe_r <= mwe_nxt;     bud_r <= bud_nxt;   off_r <= off_nxt;
    start_r <= start_nxt; addr_ph_r <= addr_ph_nxt; st_r <= st_nxt; blk_r <= blk_nxt;
    end_r <= end_nxt;     o_st_r <= o_st_nxt;   o_addr_r <= o_addr_nxt;
    o_end_r <= o_end_nxt; o_ord_r <= o_ord_nxt;
  end

endmodule

FILE: src/buddy_page_allocator.sv
// Buddy page allocator for one heap of up to MAX_PAGES pages: allocate, release and reserve
// requests each give one result. After reset the mark and tag memories are swept clear, one
// entry a cycle, over all MAX_ORDERS * 2**ceil(log2(MAX_PAGES)) mark entries (11264 at the
// defaults), during which no request is taken. One request is in work at a time: it is decoded,
// an allocate scans its order's bitmap for a free block, every entry of the chosen subtree or
// reserved range is written level by level, then an allocate marks each ancestor, a release
// clears ancestors until a marked buddy stops it, and the block address is added up.
// Depends on bpa_pkg, bpa_ifs, bpa_store and bpa_ctrl.
module buddy_page_allocator #(
  parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF,
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if.sink      in_req,
  bpa_out_if.source   out_rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  localparam int PW = $clog2(MAX_PAGES);
  localparam int AW = $clog2(MAX_ORDERS << PW);

  logic [47:0] heap_base_r;
  logic [10:0] heap_pages_r;
  logic [3:0]  orders_r;

  bpa_pkg::bpa_mem_ctl_t     mem_ctl;
  logic [AW-1:0]             mark_waddr, mark_raddr;
  logic [PW-1:0]             tag_waddr, tag_raddr;
  logic                      mark_rdata_r;
  logic [bpa_pkg::TAG_W-1:0] tag_rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      heap_pages_r <= 11'd1024;
      orders_r     <= 4'd11;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpa_pkg::CFG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
        bpa_pkg::CFG_HEAP_PAGES: heap_pages_r <= cfg_wdata[10:0];
        bpa_pkg::CFG_ORDERS:     orders_r     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  bpa_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .MAX_ORDERS(MAX_ORDERS),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req       (in_req),
    .out_rsp      (out_rsp),
    .heap_base    (heap_base_r),
    .heap_pages   (heap_pages_r),
    .orders_in_use(orders_r),
    .mem_ctl      (mem_ctl),
    .mark_waddr   (mark_waddr),
    .mark_raddr   (mark_raddr),
    .tag_waddr    (tag_waddr),
    .tag_raddr    (tag_raddr),
    .mark_rdata_r (mark_rdata_r),
    .tag_rdata_r  (tag_rdata_r)
  );

  bpa_store #(
    .MAX_PAGES (MAX_PAGES),
    .MAX_ORDERS(MAX_ORDERS)
  ) u_store (
    .clk         (clk),
    .mem_ctl     (mem_ctl),
    .mark_waddr  (mark_waddr),
    .mark_raddr  (mark_raddr),
    .tag_waddr   (tag_waddr),
    .tag_raddr   (tag_raddr),
    .mark_rdata_r(mark_rdata_r),
    .tag_rdata_r (tag_rdata_r)
  );

endmodule
